FILE: rtl/core/brute_force_tour_search_macros.svh
// Assertion macros shared by the tour search RTL.
// Define NO_ASSERTIONS to compile them away.
`ifndef BRUTE_FORCE_TOUR_SEARCH_MACROS_SVH
`define BRUTE_FORCE_TOUR_SEARCH_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge outside reset.
`define BFTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BFTS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BFTS_ASSERT(lbl, prop, msg)
`define BFTS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: rtl/core/bfts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfts_pkg;

    // Fixed field widths of the stream items.
    localparam int XY_W       = 7;
    localparam int CITY_W     = 3;
    localparam int ORDER_W    = 24;
    localparam int LEN_W      = 11;
    localparam int TIE_W      = 16;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 56;
    localparam int M_PAD_W    = M_TDATA_W - ORDER_W - LEN_W - TIE_W;
    localparam int S_PAD_W    = S_TDATA_W - 2 * XY_W;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_DRD,
        ST_DSQ,
        ST_DRT,
        ST_DWR,
        ST_WALK,
        ST_SCORE,
        ST_UPD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic step;
    } perm_ctrl_t;

    typedef struct packed {
        logic leaf;
        logic done;
    } perm_stat_t;

    typedef struct packed {
        logic start;
    } sqrt_ctrl_t;

    typedef struct packed {
        logic busy;
    } sqrt_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/bfts_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Iterative integer square root, one result bit per cycle.
module bfts_sqrt
    import bfts_pkg::*;
#(
    parameter int VW = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sqrt_ctrl_t        ctrl,
    input  wire logic [VW-1:0]     operand,
    output sqrt_stat_t             stat,
    output logic [VW/2-1:0]        root
);

    localparam int RW = VW / 2;

    logic [VW-1:0] rem_reg,  rem_next;
    logic [VW-1:0] root_reg, root_next;
    logic [VW-1:0] bit_reg,  bit_next;
    logic          busy_reg, busy_next;
    logic [VW:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        trial     = {1'b0, root_reg} + {1'b0, bit_reg};
        if (ctrl.start)
        begin
            rem_next  = operand;
            root_next = '0;
            bit_next  = VW'(1) << (VW - 2);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next  = rem_reg - trial[VW-1:0];
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next  = bit_reg >> 2;
            busy_next = !bit_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign stat.busy = busy_reg;
    assign root      = root_reg[RW-1:0];

    `include "brute_force_tour_search_macros.svh"

    `BFTS_ASSERT(a_sqrt_start_idle, ctrl.start |-> !busy_reg, "sqrt started while busy")

endmodule

`default_nettype wire

FILE: rtl/core/bfts_perm.sv
`timescale 1ns / 1ps
`default_nettype none

// Permutation walker in recursive swap order, one swap per step, with an
// explicit stack of loop indices per depth.
module bfts_perm
    import bfts_pkg::*;
#(
    parameter int CITIES = 6
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire perm_ctrl_t        ctrl,
    output perm_stat_t             stat,
    output logic [CITY_W-1:0]      ord [CITIES]
);

    localparam int IW = $clog2(CITIES + 1);
    localparam int DW = $clog2(CITIES);

    logic [CITY_W-1:0] ord_reg [CITIES];
    logic [CITY_W-1:0] ord_next [CITIES];
    logic [IW-1:0]     idx_reg [CITIES];
    logic [IW-1:0]     idx_next [CITIES];
    logic [DW-1:0]     depth_reg, depth_next;
    logic [IW-1:0]     cur_idx;
    logic [DW-1:0]     pd;
    logic [DW-1:0]     sa;
    logic [DW-1:0]     sb;

    assign cur_idx   = idx_reg[depth_reg];
    assign pd        = depth_reg - DW'(1);
    assign stat.leaf = (depth_reg == DW'(CITIES - 1));
    assign stat.done = (depth_reg == '0) && (cur_idx == IW'(CITIES));

    always_comb
    begin
        ord_next   = ord_reg;
        idx_next   = idx_reg;
        depth_next = depth_reg;
        sa         = depth_reg;
        sb         = cur_idx[DW-1:0];
        if (ctrl.start)
        begin
            for (int i = 0; i < CITIES; i++)
            begin
                ord_next[i] = CITY_W'(i);
                idx_next[i] = '0;
            end
            depth_next = '0;
        end
        else if (ctrl.step)
        begin
            if (!stat.leaf && (cur_idx != IW'(CITIES)))
            begin
                // Descend: swap this depth with its current choice.
                sa                        = depth_reg;
                sb                        = cur_idx[DW-1:0];
                ord_next[sa]              = ord_reg[sb];
                ord_next[sb]              = ord_reg[sa];
                idx_next[depth_reg + 1'b1] = IW'(depth_reg) + IW'(1);
                depth_next                = depth_reg + DW'(1);
            end
            else if (depth_reg != '0)
            begin
                // Return: undo the parent's swap and move to its next choice.
                sa             = pd;
                sb             = idx_reg[pd][DW-1:0];
                ord_next[sa]   = ord_reg[sb];
                ord_next[sb]   = ord_reg[sa];
                idx_next[pd]   = idx_reg[pd] + IW'(1);
                depth_next     = pd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CITIES; i++)
            begin
                ord_reg[i] <= CITY_W'(i);
                idx_reg[i] <= '0;
            end
            depth_reg <= '0;
        end
        else
        begin
            ord_reg   <= ord_next;
            idx_reg   <= idx_next;
            depth_reg <= depth_next;
        end
    end

    assign ord = ord_reg;

    `include "brute_force_tour_search_macros.svh"

    `BFTS_ASSERT(a_perm_no_step_done, ctrl.step |-> !stat.done, "step after walk finished")

endmodule

`default_nettype wire

FILE: rtl/core/brute_force_tour_search.sv
// Throughput: one city transfer per cycle while loading; no transfer is taken during a search.
// Table build: N*N distances, each read from the coordinate store, squared, rooted in one
// iterative square root unit and written. Walk: each tour takes N+1 table reads, a record
// update and a walker step, other swap steps take a walker step each; m_tvalid rises at walk end.
// Reset (rst_n, asynchronous, active low) clears the sequencer, the walker and the load count;
// the coordinate and distance memories hold no reset value.
`timescale 1ns / 1ps
`default_nettype none

module brute_force_tour_search
    import bfts_pkg::*;
#(
    parameter int CITIES     = 6,
    parameter int COORD_BITS = 7
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // city_x[6:0], city_y[13:7], zero fill
    input  wire logic                 s_tlast,   // last_city
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata    // best_order[23:0], best_length[34:24],
                                                 // tie_count[50:35], zero fill
);

    // Coordinates wider than the port carry nothing more, so the kept width saturates there.
    localparam int CW  = (COORD_BITS < XY_W) ? COORD_BITS : XY_W;
    localparam int RW  = CW + 1;          // distance width
    localparam int VW  = 2 * RW;          // squared distance width, even for the root unit
    localparam int CAW = $clog2(CITIES);
    localparam int LCW = $clog2(CITIES + 1);
    localparam int DAW = $clog2(CITIES * CITIES);
    localparam int KW  = $clog2(CITIES + 1);

    state_t state_reg, state_next;

    // The coordinate store holds y above x for each city.
    logic [2*CW-1:0]  cmem [CITIES];
    logic [2*CW-1:0]  ca_reg, cb_reg;
    logic [RW-1:0]    dmem [CITIES*CITIES];
    logic [RW-1:0]    dq_reg;

    logic [LCW-1:0]   loaded_reg, loaded_next;
    logic [CAW-1:0]   ci_reg, ci_next, cj_reg, cj_next;
    logic [DAW-1:0]   daddr_reg, daddr_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [LEN_W-1:0] total_reg, total_next;
    logic [LEN_W-1:0] best_len_reg, best_len_next;
    logic [TIE_W-1:0] ties_reg, ties_next;
    logic [ORDER_W-1:0] border_reg, border_next;
    logic             found_reg, found_next;

    logic             s_acc;
    logic             m_acc;
    logic             cwr_en;
    logic             dwr_en;
    logic             last_pair;
    logic [CW-1:0]    dx, dy;
    logic [VW-1:0]    sq_sum;
    logic [DAW-1:0]   raddr;
    logic [CAW-1:0]   kidx, nidx;
    logic [ORDER_W-1:0] cur_word;

    perm_ctrl_t        perm_ctrl;
    perm_stat_t        perm_stat;
    logic [CITY_W-1:0] ord [CITIES];
    sqrt_ctrl_t        sqrt_ctrl;
    sqrt_stat_t        sqrt_stat;
    logic [RW-1:0]     root;

    bfts_sqrt #(
        .VW (VW)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (sqrt_ctrl),
        .operand (sq_sum),
        .stat    (sqrt_stat),
        .root    (root)
    );

    bfts_perm #(
        .CITIES (CITIES)
    ) u_perm (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (perm_ctrl),
        .stat  (perm_stat),
        .ord   (ord)
    );

    assign s_acc     = s_tvalid && s_tready;
    assign m_acc     = m_tvalid && m_tready;
    assign last_pair = (ci_reg == CAW'(CITIES - 1)) && (cj_reg == CAW'(CITIES - 1));

    // Absolute coordinate differences of the pair read from the store.
    assign dx = (ca_reg[CW-1:0] > cb_reg[CW-1:0]) ? ca_reg[CW-1:0] - cb_reg[CW-1:0]
                                                  : cb_reg[CW-1:0] - ca_reg[CW-1:0];
    assign dy = (ca_reg[2*CW-1:CW] > cb_reg[2*CW-1:CW]) ?
                ca_reg[2*CW-1:CW] - cb_reg[2*CW-1:CW] :
                cb_reg[2*CW-1:CW] - ca_reg[2*CW-1:CW];
    assign sq_sum = VW'(dx) * VW'(dx) + VW'(dy) * VW'(dy);

    // Edge from tour position k to the next position, wrapping to the start.
    assign kidx  = (k_reg < KW'(CITIES)) ? k_reg[CAW-1:0] : '0;
    assign nidx  = (kidx == CAW'(CITIES - 1)) ? '0 : kidx + CAW'(1);
    assign raddr = DAW'(ord[kidx]) * DAW'(CITIES) + DAW'(ord[nidx]);

    always_comb
    begin
        cur_word = '0;
        for (int p = 0; p < CITIES; p++)
        begin
            cur_word[p*CITY_W +: CITY_W] = ord[p];
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_acc && s_tlast)
                begin
                    state_next = ST_DRD;
                end
            end
            ST_DRD:   state_next = ST_DSQ;
            ST_DSQ:   state_next = ST_DRT;
            ST_DRT:
            begin
                if (!sqrt_stat.busy)
                begin
                    state_next = ST_DWR;
                end
            end
            ST_DWR:   state_next = last_pair ? ST_WALK : ST_DRD;
            ST_WALK:
            begin
                if (perm_stat.done)
                begin
                    state_next = ST_OUT;
                end
                else if (perm_stat.leaf)
                begin
                    state_next = ST_SCORE;
                end
            end
            ST_SCORE:
            begin
                if (k_reg == KW'(CITIES))
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:   state_next = ST_WALK;
            ST_OUT:
            begin
                if (m_acc)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:  state_next = ST_LOAD;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_tready        = 1'b0;
        m_tvalid        = 1'b0;
        perm_ctrl.start = 1'b0;
        perm_ctrl.step  = 1'b0;
        sqrt_ctrl.start = 1'b0;
        cwr_en          = 1'b0;
        dwr_en          = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                cwr_en   = s_tvalid && (loaded_reg < LCW'(CITIES));
            end
            ST_DSQ:   sqrt_ctrl.start = 1'b1;
            ST_DWR:
            begin
                dwr_en          = 1'b1;
                perm_ctrl.start = last_pair;
            end
            ST_WALK:  perm_ctrl.step = !perm_stat.done && !perm_stat.leaf;
            ST_UPD:   perm_ctrl.step = 1'b1;
            ST_OUT:   m_tvalid = 1'b1;
            default:
            begin
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        loaded_next   = loaded_reg;
        ci_next       = ci_reg;
        cj_next       = cj_reg;
        daddr_next    = daddr_reg;
        k_next        = k_reg;
        total_next    = total_reg;
        best_len_next = best_len_reg;
        ties_next     = ties_reg;
        border_next   = border_reg;
        found_next    = found_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_acc)
                begin
                    if (loaded_reg < LCW'(CITIES))
                    begin
                        loaded_next = loaded_reg + LCW'(1);
                    end
                    if (s_tlast)
                    begin
                        // A new search starts from an empty record.
                        loaded_next   = '0;
                        ci_next       = '0;
                        cj_next       = '0;
                        daddr_next    = '0;
                        found_next    = 1'b0;
                        best_len_next = '1;
                        ties_next     = '0;
                        border_next   = '0;
                    end
                end
            end
            ST_DWR:
            begin
                daddr_next = daddr_reg + DAW'(1);
                if (cj_reg == CAW'(CITIES - 1))
                begin
                    cj_next = '0;
                    ci_next = ci_reg + CAW'(1);
                end
                else
                begin
                    cj_next = cj_reg + CAW'(1);
                end
            end
            ST_WALK:
            begin
                k_next     = '0;
                total_next = '0;
            end
            ST_SCORE:
            begin
                // Table data is registered, so it arrives in the cycle after its address.
                k_next = k_reg + KW'(1);
                if (k_reg != '0)
                begin
                    total_next = total_reg + LEN_W'(dq_reg);
                end
            end
            ST_UPD:
            begin
                if (!found_reg || (total_reg < best_len_reg))
                begin
                    found_next    = 1'b1;
                    best_len_next = total_reg;
                    ties_next     = TIE_W'(1);
                    border_next   = cur_word;
                end
                else if (total_reg == best_len_reg)
                begin
                    ties_next = ties_reg + TIE_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            loaded_reg <= '0;
            found_reg  <= 1'b0;
            ci_reg     <= '0;
            cj_reg     <= '0;
            daddr_reg  <= '0;
            k_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            loaded_reg <= loaded_next;
            found_reg  <= found_next;
            ci_reg     <= ci_next;
            cj_reg     <= cj_next;
            daddr_reg  <= daddr_next;
            k_reg      <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg    <= total_next;
        best_len_reg <= best_len_next;
        ties_reg     <= ties_next;
        border_reg   <= border_next;
    end

    // Coordinate store: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (cwr_en)
        begin
            cmem[loaded_reg[CAW-1:0]] <= {s_tdata[XY_W +: CW], s_tdata[CW-1:0]};
        end
        ca_reg <= cmem[ci_reg];
        cb_reg <= cmem[cj_reg];
    end

    // Distance table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (dwr_en)
        begin
            dmem[daddr_reg] <= root;
        end
        dq_reg <= dmem[raddr];
    end

    assign m_tdata = {{M_PAD_W{1'b0}}, ties_reg, best_len_reg, border_reg};

    `include "brute_force_tour_search_macros.svh"

    `BFTS_ASSERT_ALWAYS(a_ready_valid_excl, !(s_tready && m_tvalid), "ready while result held")
    `BFTS_ASSERT(a_ties_nonzero, m_tvalid |-> (ties_reg != '0), "result with no tour counted")
    `BFTS_ASSERT(a_out_after_walk, $rose(m_tvalid) |-> $past(perm_stat.done), "result before walk end")

endmodule

`default_nettype wire
